// ===== rtl/core/dfa_pkg.sv =====
package dfa_pkg;

  // Verdict codes carried in the result beat
  localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
  localparam logic [1:0] VERDICT_REJECT  = 2'd1;
  localparam logic [1:0] VERDICT_INVALID = 2'd2;

  // Input item kinds (tuser)
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CHAR  = 1'b1;

  // Register indexes (paddr[4:3])
  localparam logic [1:0] REG_START_STATE = 2'd0;
  localparam logic [1:0] REG_ALPHA_SIZE  = 2'd1;
  localparam logic [1:0] REG_ALPHA_CHARS = 2'd2;
  localparam logic [1:0] REG_ACCEPT_MASK = 2'd3;

  localparam int STATE_W   = 4;
  localparam int CHAR_W    = 8;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // take the input beat: write entry or start a lookup
    logic step;     // apply the lookup result, emit on last character
  } dfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_op;      // kind of the beat offered at the input
    logic last;       // captured character closes the string
    logic slot_free;  // output register can take a result this cycle
  } dfa_sts_t;

endpackage

// ===== rtl/core/dfa_ram.sv =====
module dfa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dfa_ctrl.sv =====
module dfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dfa_pkg::dfa_sts_t sts_i,
  output dfa_pkg::dfa_cmd_t cmd_o
);
  import dfa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_STEP = 1'b1;

  logic state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i && (sts_i.in_op == OP_CHAR)) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        // a last character waits until the output register is free
        if (!sts_i.last || sts_i.slot_free) begin
          cmd_o.step = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/dfa_dpath.sv =====
module dfa_dpath #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 8,
  parameter int ADDR_W      = 7
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [dfa_pkg::APB_DATA_W-1:0]   cfg_wdata_i,
  output logic [dfa_pkg::APB_DATA_W-1:0]   cfg_rdata_o,
  // input payload
  input  logic [dfa_pkg::IN_DATA_W-1:0]    in_data_i,
  input  logic                             in_op_i,
  input  logic                             in_last_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dfa_pkg::OUT_DATA_W-1:0]   out_data_o,
  // transition memory port
  output logic                             ram_en_o,
  output logic                             ram_we_o,
  output logic [ADDR_W-1:0]                ram_addr_o,
  output logic [dfa_pkg::STATE_W-1:0]      ram_wdata_o,
  input  logic [dfa_pkg::STATE_W-1:0]      ram_rdata_i,
  // controller
  input  dfa_pkg::dfa_cmd_t                cmd_i,
  output dfa_pkg::dfa_sts_t                sts_o
);
  import dfa_pkg::*;

  localparam int SYM_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  // Configuration registers
  logic [STATE_W-1:0] start_q;
  logic [3:0]         alpha_size_q;
  logic [63:0]        alpha_chars_q;
  logic [15:0]        accept_mask_q;

  // Walk state
  logic [STATE_W-1:0] state_q, state_d;
  logic               bad_q, bad_d;

  // Captured character beat
  logic               last_q;
  logic               hit_q;
  logic               oob_q;

  // Result register
  logic               out_valid_q;
  logic [1:0]         verdict_q;
  logic [STATE_W-1:0] end_q;

  // Input fields
  logic [CHAR_W-1:0]  char_code;
  logic [3:0]         row_state;
  logic [2:0]         column_symbol;
  logic [STATE_W-1:0] target_state;

  assign char_code     = in_data_i[7:0];
  assign row_state     = in_data_i[11:8];
  assign column_symbol = in_data_i[14:12];
  assign target_state  = in_data_i[18:15];

  // Parallel alphabet compare, lowest index wins
  logic             hit;
  logic [SYM_W-1:0] sym;

  always_comb begin
    hit = 1'b0;
    sym = '0;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if ((4'(k) < alpha_size_q) && (alpha_chars_q[8*k +: 8] == char_code)) begin
        hit = 1'b1;
        sym = SYM_W'(k);
      end
    end
  end

  // Memory address: entry writes or lookup of the present state
  logic wr_ok;
  logic st_oob;

  assign wr_ok  = (32'(row_state) < MAX_STATES) && (32'(column_symbol) < MAX_SYMBOLS);
  assign st_oob = !(32'(state_q) < MAX_STATES);

  always_comb begin
    ram_en_o    = cmd_i.capture && ((in_op_i == OP_CHAR) || wr_ok);
    ram_we_o    = (in_op_i == OP_WRITE);
    ram_wdata_o = target_state;
    if (in_op_i == OP_WRITE) begin
      ram_addr_o = ADDR_W'(32'(row_state) * MAX_SYMBOLS + 32'(column_symbol));
    end else begin
      ram_addr_o = ADDR_W'(32'(state_q) * MAX_SYMBOLS + 32'(sym));
    end
  end

  // Step: next state and invalid flag after this character
  always_comb begin
    state_d = state_q;
    bad_d   = bad_q;
    if (!bad_q) begin
      if (!hit_q) begin
        bad_d = 1'b1;
      end else if (oob_q) begin
        state_d = '0;
      end else begin
        state_d = ram_rdata_i;
      end
    end
  end

  logic slot_free;
  assign slot_free = !out_valid_q || out_ready_i;

  // Capture the character beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      last_q <= in_last_i;
      hit_q  <= hit;
      oob_q  <= st_oob;
    end
  end

  // Configuration and walk state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q       <= '0;
      alpha_size_q  <= 4'd1;
      alpha_chars_q <= '0;
      accept_mask_q <= '0;
      state_q       <= '0;
      bad_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_START_STATE: begin
            start_q <= cfg_wdata_i[3:0];
            state_q <= cfg_wdata_i[3:0];
            bad_q   <= 1'b0;
          end
          REG_ALPHA_SIZE:  alpha_size_q  <= cfg_wdata_i[3:0];
          REG_ALPHA_CHARS: alpha_chars_q <= cfg_wdata_i;
          REG_ACCEPT_MASK: accept_mask_q <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end else if (cmd_i.step) begin
        if (last_q) begin
          state_q <= start_q;
          bad_q   <= 1'b0;
        end else begin
          state_q <= state_d;
          bad_q   <= bad_d;
        end
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.step && last_q) begin
      end_q <= state_d;
      if (bad_d) begin
        verdict_q <= VERDICT_INVALID;
      end else if (accept_mask_q[state_d]) begin
        verdict_q <= VERDICT_ACCEPT;
      end else begin
        verdict_q <= VERDICT_REJECT;
      end
    end
  end

  // Register read back
  always_comb begin
    unique case (cfg_idx_i)
      REG_START_STATE: cfg_rdata_o = {60'd0, start_q};
      REG_ALPHA_SIZE:  cfg_rdata_o = {60'd0, alpha_size_q};
      REG_ALPHA_CHARS: cfg_rdata_o = alpha_chars_q;
      REG_ACCEPT_MASK: cfg_rdata_o = {48'd0, accept_mask_q};
      default:         cfg_rdata_o = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {2'b00, end_q, verdict_q};

  assign sts_o.in_op     = in_op_i;
  assign sts_o.last      = last_q;
  assign sts_o.slot_free = slot_free;

endmodule

// ===== rtl/core/dfa_string_recognizer.sv =====
// Table-driven DFA recognizer. Program the alphabet (up to eight byte characters,
// byte k is symbol k), its size, the start state and the accepting-state mask over
// the APB port (64-bit registers at byte addresses 0, 8, 16, 24), then fill the
// transition memory with write beats (tuser 0) and stream characters (tuser 1).
// A write beat is taken in the idle state; a character beat also needs the step
// state, as the transition-memory read is registered and sits inside the state
// loop. A character outside the alphabet freezes the string; a character beat
// with tlast set returns one result beat (accepted, rejected or invalid symbol,
// plus the end state) and reloads the start state. A finished result is held
// in an output register; a further last character waits while it is full and
// unread. Transition entries read before they are written return unknown data.
module dfa_string_recognizer #(
  parameter int MAX_STATES  = 16,
  parameter int MAX_SYMBOLS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dfa_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dfa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dfa_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] char_code, [11:8] row_state, [14:12] column_symbol,
  // [18:15] target_state, [23:19] zero
  input  logic [dfa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tlast,  // last_char
  input  logic                             s_axis_tuser,  // [0] op
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] verdict, [5:2] end_state, [7:6] zero
  output logic [dfa_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import dfa_pkg::*;

  localparam int DEPTH  = MAX_STATES * MAX_SYMBOLS;
  localparam int ADDR_W = $clog2(DEPTH);

  dfa_cmd_t           cmd;
  dfa_sts_t           sts;
  logic               ram_en;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [STATE_W-1:0] ram_wdata;
  logic [STATE_W-1:0] ram_rdata;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  dfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dfa_dpath #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .ADDR_W      (ADDR_W)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (paddr[4:3]),
    .cfg_wdata_i (pwdata),
    .cfg_rdata_o (prdata),
    .in_data_i   (s_axis_tdata),
    .in_op_i     (s_axis_tuser),
    .in_last_i   (s_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  dfa_ram #(
    .WIDTH (STATE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import dfa_pkg::*;

  localparam int NUM_PHASES  = 10;
  localparam int PHASE_BEATS = 140;
  localparam int SETTLE      = 4;
  localparam int CYCLE_LIMIT = 1000000;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;

  typedef struct {
    bit       op;
    bit [7:0] ch;
    bit       last;
    bit [3:0] row;
    bit [2:0] col;
    bit [3:0] tgt;
  } dfa_beat_t;

  typedef struct {
    bit [1:0] verdict;
    bit [3:0] end_state;
  } dfa_result_t;

  typedef struct {
    row_kind_e   kind;
    dfa_beat_t   beat;
    bit [1:0]    reg_idx;
    bit [63:0]   reg_val;
    bit          typed;
    dfa_result_t want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow of the recognizer: registers, transition table, walk state
  bit [3:0]    cfg_start;
  bit [3:0]    cfg_size;
  bit [63:0]   cfg_chars;
  bit [15:0]   cfg_mask;
  bit [3:0]    trans_mem [128];
  bit          trans_written [128];
  bit [3:0]    dfa_state;
  bit          dfa_bad;

  dfa_result_t verdict_q [$];
  plan_row_t   plan_q [$];
  int          error_count;
  int          cycle_count = 0;
  bit          quiet;

  dfa_string_recognizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Parallel compare against the alphabet, lowest index wins
  function automatic int lookup_symbol(input bit [7:0] ch);
    int n;
    n = (cfg_size > 4'd8) ? 8 : int'(cfg_size);
    for (int k = 0; k < n; k++) begin
      if (cfg_chars[8*k +: 8] == ch) return k;
    end
    return -1;
  endfunction

  task automatic apply_reg(input bit [1:0] idx, input bit [63:0] val);
    case (idx)
      REG_START_STATE: begin
        cfg_start = val[3:0];
        dfa_state = val[3:0];
        dfa_bad   = 1'b0;
      end
      REG_ALPHA_SIZE:  cfg_size  = val[3:0];
      REG_ALPHA_CHARS: cfg_chars = val;
      REG_ACCEPT_MASK: cfg_mask  = val[15:0];
      default: ;
    endcase
  endtask

  // One accepted input beat through the recognizer shadow
  task automatic step_dfa(input dfa_beat_t b, output bit emits, output dfa_result_t r);
    int sym;
    emits       = 1'b0;
    r.verdict   = VERDICT_ACCEPT;
    r.end_state = '0;
    if (b.op == OP_WRITE) begin
      trans_mem[{b.row, b.col}]     = b.tgt;
      trans_written[{b.row, b.col}] = 1'b1;
      return;
    end
    if (!dfa_bad) begin
      sym = lookup_symbol(b.ch);
      if (sym < 0) dfa_bad = 1'b1;
      else dfa_state = trans_mem[{dfa_state, sym[2:0]}];
    end
    if (b.last) begin
      emits = 1'b1;
      if (dfa_bad) r.verdict = VERDICT_INVALID;
      else r.verdict = cfg_mask[dfa_state] ? VERDICT_ACCEPT : VERDICT_REJECT;
      r.end_state = dfa_state;
      dfa_state   = cfg_start;
      dfa_bad     = 1'b0;
    end
  endtask

  // Table builders
  function automatic plan_row_t chr(bit [7:0] ch, bit last, bit typed = 1'b0,
                                    bit [1:0] v = 2'd0, bit [3:0] e = 4'd0);
    plan_row_t r;
    r.kind    = ROW_BEAT;
    r.beat    = '{OP_CHAR, ch, last, 4'd0, 3'd0, 4'd0};
    r.reg_idx = REG_START_STATE;
    r.reg_val = '0;
    r.typed   = typed;
    r.want    = '{v, e};
    return r;
  endfunction

  function automatic plan_row_t wr(bit [3:0] row, bit [2:0] col, bit [3:0] tgt, bit last);
    plan_row_t r;
    r      = chr(8'h00, last);
    r.beat = '{OP_WRITE, 8'h00, last, row, col, tgt};
    return r;
  endfunction

  function automatic plan_row_t cfg(bit [1:0] idx, bit [63:0] val);
    plan_row_t r;
    r         = chr(8'h00, 1'b0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Input beat: optional gap, hold until accepted, then predict
  task automatic send_beat(input dfa_beat_t b, input bit typed, input dfa_result_t want);
    bit          emits;
    dfa_result_t r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, b.tgt, b.col, b.row, b.ch};
    s_axis_tlast  <= b.last;
    s_axis_tuser  <= b.op;
    do @(posedge clk_i); while (!s_axis_tready);
    step_dfa(b, emits, r);
    if (emits) verdict_q.push_back(typed ? want : r);
  endtask

  task automatic send_write(input bit [3:0] row, input bit [2:0] col);
    dfa_beat_t b;
    b.op   = OP_WRITE;
    b.ch   = 8'($urandom);
    b.last = 1'($urandom);
    b.row  = row;
    b.col  = col;
    b.tgt  = 4'($urandom);
    send_beat(b, 1'b0, '{2'd0, 4'd0});
  endtask

  // Character beat; an entry about to be read for the first time is filled first
  task automatic send_char(input bit [7:0] ch, input bit last);
    dfa_beat_t b;
    int        sym;
    if (!dfa_bad) begin
      sym = lookup_symbol(ch);
      if (sym >= 0 && !trans_written[{dfa_state, sym[2:0]}])
        send_write(dfa_state, sym[2:0]);
    end
    b = '{OP_CHAR, ch, last, 4'($urandom), 3'($urandom), 4'($urandom)};
    send_beat(b, 1'b0, '{2'd0, 4'd0});
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // APB write: setup, access, then idle
  task automatic write_reg(input bit [1:0] idx, input bit [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    apply_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic bit [63:0] rand_chars();
    bit [63:0] c;
    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 9))
        0: c[8*k +: 8] = 8'h00;
        1: c[8*k +: 8] = 8'hFF;
        2: c[8*k +: 8] = (k > 0) ? c[8*($urandom_range(0, k-1)) +: 8] : 8'h5A;
        default: c[8*k +: 8] = 8'($urandom);
      endcase
    end
    return c;
  endfunction

  // Per-phase register settings, extremes first
  task automatic setup_phase(input int p);
    bit [63:0] v;
    v = {$urandom, $urandom};
    write_reg(REG_ALPHA_CHARS, rand_chars());
    v[3:0] = (p == 0) ? 4'd1 : (p == 1) ? 4'd8 : (p == 3) ? 4'd15 : 4'($urandom_range(1, 8));
    write_reg(REG_ALPHA_SIZE, v);
    v = {$urandom, $urandom};
    if (p == 0) v[15:0] = 16'hFFFF;
    if (p == 1) v[15:0] = 16'h0000;
    write_reg(REG_ACCEPT_MASK, v);
    v = {$urandom, $urandom};
    if (p == 0) v[3:0] = 4'd0;
    if (p == 1) v[3:0] = 4'd15;
    if (p < 4 || $urandom_range(0, 1) == 0) write_reg(REG_START_STATE, v);
  endtask

  // Strings of mostly alphabet characters, some noise and stray writes
  task automatic run_phase();
    int sent;
    int len;
    int n;
    bit open;
    bit [7:0] ch;
    sent = 0;
    while (sent < PHASE_BEATS) begin
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
      open = ($urandom_range(0, 9) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_write(4'($urandom), 3'($urandom));
          sent++;
        end
        n = (cfg_size > 4'd8) ? 8 : int'(cfg_size);
        if (n > 0 && $urandom_range(0, 9) != 0) ch = cfg_chars[8*$urandom_range(0, n-1) +: 8];
        else ch = 8'($urandom);
        send_char(ch, (i == len - 1) && !open);
        sent++;
      end
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    dfa_result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", m_axis_tdata));
      end else begin
        e = verdict_q.pop_front();
        if (m_axis_tdata[1:0] !== e.verdict)
          report_mismatch($sformatf("verdict %0d, want %0d", m_axis_tdata[1:0], e.verdict));
        if (m_axis_tdata[5:2] !== e.end_state)
          report_mismatch($sformatf("end_state %0d, want %0d",
                                    m_axis_tdata[5:2], e.end_state));
      end
    end
  end

  // Result side backpressure
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
      if (!quiet) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  initial begin
    error_count = 0;
    quiet       = 1'b0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    s_axis_tuser  <= OP_WRITE;
    cfg_start = 4'd0;
    cfg_size  = 4'd1;
    cfg_chars = '0;
    cfg_mask  = '0;
    dfa_state = 4'd0;
    dfa_bad   = 1'b0;
    foreach (trans_mem[i]) begin
      trans_mem[i]     = '0;
      trans_written[i] = 1'b0;
    end

    // Directed rows; typed verdicts where the outcome is plain
    plan_q = '{
      chr(8'h41, 1'b1, 1'b1, VERDICT_INVALID, 4'd0),   // reset alphabet is only 0x00
      chr(8'hFF, 1'b0),                                // bad symbol freezes the string
      chr(8'h00, 1'b1, 1'b1, VERDICT_INVALID, 4'd0),   // rest of string ignored
      wr(4'd0, 3'd0, 4'd15, 1'b1),                     // tlast on a write is ignored
      chr(8'h00, 1'b1, 1'b1, VERDICT_REJECT, 4'd15),
      cfg(REG_ACCEPT_MASK, 64'hFFFF_FFFF_FFFF_8001),
      chr(8'h00, 1'b1, 1'b1, VERDICT_ACCEPT, 4'd15),
      wr(4'd15, 3'd7, 4'd0, 1'b0),
      cfg(REG_ALPHA_CHARS, 64'h017F_8061_6261_FF00),   // 0x61 at symbols 2 and 4
      cfg(REG_ALPHA_SIZE, 64'hFFFF_FFFF_FFFF_FFF8),
      cfg(REG_START_STATE, 64'h0000_0000_0000_00FF),
      chr(8'h01, 1'b0),
      wr(4'd0, 3'd0, 4'd7, 1'b0),                      // write in the middle of a string
      chr(8'h00, 1'b1),
      wr(4'd15, 3'd2, 4'd3, 1'b0),
      wr(4'd15, 3'd4, 4'd9, 1'b1),
      chr(8'h61, 1'b1),                                // lowest duplicate wins
      chr(8'h01, 1'b0),
      cfg(REG_START_STATE, 64'h0000_0000_0000_000F),   // restarts the open string
      chr(8'h01, 1'b1),
      cfg(REG_ALPHA_SIZE, 64'h0),                      // empty alphabet
      chr(8'h00, 1'b1, 1'b1, VERDICT_INVALID, 4'd15),
      cfg(REG_ALPHA_SIZE, 64'hF),                      // clamps to eight entries
      chr(8'h01, 1'b0),
      chr(8'h55, 1'b0),
      chr(8'h01, 1'b1, 1'b1, VERDICT_INVALID, 4'd0)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      if (plan_q[i].kind == ROW_REG) begin
        wait_idle();
        write_reg(plan_q[i].reg_idx, plan_q[i].reg_val);
      end else begin
        send_beat(plan_q[i].beat, plan_q[i].typed, plan_q[i].want);
      end
    end

    // Random phases, the last one without any idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      setup_phase(p);
      run_phase();
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (verdict_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/dfa_pkg.sv
rtl/core/dfa_ram.sv
rtl/core/dfa_ctrl.sv
rtl/core/dfa_dpath.sv
rtl/core/dfa_string_recognizer.sv
bench/tb_top.sv
